### design/jwa_pkg.sv
// jwa_pkg: shared beat types and codes for the job weight admission block
// no dependencies
`timescale 1ns / 1ps

package jwa_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  family;
    logic [3:0]  job_level;
    logic [63:0] file_size;
    logic        last_file;
    logic [4:0]  release_weight;
  } in_beat_t;

  typedef struct packed {
    logic       accepted;
    logic [4:0] job_weight;
    logic [6:0] kept_files;
    logic [2:0] status;
  } out_beat_t;

  localparam logic [1:0] CMD_FILE       = 2'd0;
  localparam logic [1:0] CMD_RELEASE    = 2'd1;
  localparam logic [1:0] CMD_CLEAR_FAM  = 2'd2;
  localparam logic [1:0] CMD_CLEAR_ALL  = 2'd3;

  localparam logic [2:0] STAT_ADMITTED  = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_BUSY      = 3'd2;
  localparam logic [2:0] STAT_SERIAL    = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd4;

  localparam logic REG_MIN_FILES = 1'b0;
  localparam logic REG_PARALLEL  = 1'b1;

  localparam int MIN_FILES_RESET = 4;

endpackage

### design/job_weight_admission.sv
// job_weight_admission: loads job file sizes, trims level-0 jobs, admits by weight
// depends on jwa_pkg
// a non-last file item, a family clear or a full clear is done in ST_IDLE; a release passes ST_REL
// a last file item passes ST_CALC and ST_DEC, each trimmed file adding ST_SUB and ST_CALC again;
// ST_DEC waits while the output register is held by stall; in_stall holds input outside ST_IDLE
// the trim loop reads file sizes through the single size memory read port, one file per pass
// reset: control state, job state and weight set valid bits clear; memories need no pass
`timescale 1ns / 1ps

module job_weight_admission #(
  parameter int MAX_FILES = 64,
  parameter int FAMILIES  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  jwa_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jwa_pkg::out_beat_t out_data,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  localparam int CW     = $clog2(MAX_FILES + 1);
  localparam int AW     = $clog2(MAX_FILES);
  localparam int TW     = 64 + CW;
  localparam int MW     = (CW > 7) ? CW : 7;
  localparam int FIDX_W = (FAMILIES > 1) ? $clog2(FAMILIES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_DEC  = 3'd2;
  localparam logic [2:0] ST_SUB  = 3'd3;
  localparam logic [2:0] ST_REL  = 3'd4;

  logic [2:0]        state;
  logic [6:0]        min_files;
  logic              parallel_enabled;

  logic [CW-1:0]     file_count;
  logic [TW-1:0]     total;
  logic              overflow;
  logic [FIDX_W-1:0] fam_q;
  logic [3:0]        level_q;
  logic [4:0]        rel_q;
  logic [4:0]        weight_q;

  logic [63:0]       size_mem [MAX_FILES];
  logic [63:0]       size_rd;
  logic [31:0]       set_mem [FAMILIES];
  logic [31:0]       set_rd;
  logic              set_rd_vld;
  logic [FAMILIES-1:0] set_vld;

  logic [FIDX_W-1:0] fam_map [16];
  logic [FIDX_W-1:0] fam_in;
  logic              in_acc;
  logic              file_beat;
  logic              set_re;
  logic              set_we;
  logic [31:0]       set_wdata;
  logic              size_we;
  logic              size_re;
  logic [AW-1:0]     size_raddr;
  logic [63:0]       tot_sat;
  logic [4:0]        weight_calc;
  logic [31:0]       set_cur;
  logic              busy;
  logic              trim;
  logic              out_free;
  logic              out_load;
  logic              admit;
  jwa_pkg::out_beat_t result;

  for (genvar g = 0; g < 16; g++) begin : g_fam
    assign fam_map[g] = FIDX_W'(g % FAMILIES);
  end

  assign fam_in    = fam_map[in_data.family];
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && (state == ST_IDLE);
  assign file_beat = in_acc && (in_data.command == jwa_pkg::CMD_FILE);
  assign out_free  = !out_valid || !out_stall;

  // weight = top set bit index / 2, saturated total gives 31
  always_comb begin
    tot_sat     = (|total[TW-1:64]) ? '1 : total[63:0];
    weight_calc = '0;
    for (int i = 0; i < 32; i++) begin
      if (|tot_sat[2*i +: 2]) begin
        weight_calc = 5'(i);
      end
    end
  end

  assign set_cur = set_rd_vld ? set_rd : '0;
  assign busy    = set_cur[weight_q];
  assign trim    = !overflow && (level_q == 4'd0) &&
                   (MW'(file_count) > MW'(min_files)) && busy;
  assign out_load = (state == ST_DEC) && !trim && out_free;

  always_comb begin
    admit  = 1'b0;
    result = '0;
    if (overflow) begin
      result.status = jwa_pkg::STAT_OVERFLOW;
    end else begin
      result.kept_files = 7'(file_count);
      result.job_weight = weight_q;
      if (file_count == '0) begin
        result.job_weight = '0;
        result.status     = jwa_pkg::STAT_EMPTY;
      end else if (!parallel_enabled && (set_cur != '0)) begin
        result.status = jwa_pkg::STAT_SERIAL;
      end else if (busy) begin
        result.status = jwa_pkg::STAT_BUSY;
      end else begin
        result.status   = jwa_pkg::STAT_ADMITTED;
        result.accepted = 1'b1;
        admit           = 1'b1;
      end
    end
  end

  assign set_re = in_acc && (in_data.command == jwa_pkg::CMD_RELEASE ||
                  (in_data.command == jwa_pkg::CMD_FILE && in_data.last_file));
  assign set_we = (state == ST_REL) ||
                  ((state == ST_DEC) && !trim && out_free && admit);
  assign set_wdata = (state == ST_REL) ? (set_cur & ~(32'd1 << rel_q))
                                       : (set_cur | (32'd1 << weight_q));

  assign size_we    = file_beat && (file_count < CW'(MAX_FILES));
  assign size_re    = (state == ST_DEC) && trim;
  assign size_raddr = AW'(file_count - CW'(1));

  // weight set memory
  always_ff @(posedge clk) begin
    if (set_we) begin
      set_mem[fam_q] <= set_wdata;
    end
    if (set_re) begin
      set_rd <= set_mem[fam_in];
    end
  end

  // file size memory
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[file_count[AW-1:0]] <= in_data.file_size;
    end
    if (size_re) begin
      size_rd <= size_mem[size_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      min_files        <= 7'(jwa_pkg::MIN_FILES_RESET);
      parallel_enabled <= 1'b1;
      file_count       <= '0;
      total            <= '0;
      overflow         <= 1'b0;
      set_vld          <= '0;
      set_rd_vld       <= 1'b0;
      out_valid        <= 1'b0;
      out_data         <= '0;
      fam_q            <= '0;
      level_q          <= '0;
      rel_q            <= '0;
      weight_q         <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == jwa_pkg::REG_MIN_FILES) begin
          min_files <= cfg_data;
        end else begin
          parallel_enabled <= cfg_data[0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (set_re) begin
        set_rd_vld <= set_vld[fam_in];
      end
      if (set_we) begin
        set_vld[fam_q] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            fam_q   <= fam_in;
            level_q <= in_data.job_level;
            rel_q   <= in_data.release_weight;
            case (in_data.command)
              jwa_pkg::CMD_FILE: begin
                if (size_we) begin
                  file_count <= file_count + CW'(1);
                  total      <= total + TW'(in_data.file_size);
                end else begin
                  overflow <= 1'b1;
                end
                if (in_data.last_file) begin
                  state <= ST_CALC;
                end
              end
              jwa_pkg::CMD_RELEASE: begin
                state <= ST_REL;
              end
              jwa_pkg::CMD_CLEAR_FAM: begin
                set_vld[fam_in] <= 1'b0;
              end
              jwa_pkg::CMD_CLEAR_ALL: begin
                set_vld <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CALC: begin
          weight_q <= weight_calc;
          state    <= ST_DEC;
        end
        ST_DEC: begin
          if (trim) begin
            state <= ST_SUB;
          end else if (out_free) begin
            out_data   <= result;
            file_count <= '0;
            total      <= '0;
            overflow   <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_SUB: begin
          total      <= total - TW'(size_rd);
          file_count <= file_count - CW'(1);
          state      <= ST_CALC;
        end
        ST_REL: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
